// ----- hdl/audio_filter_level_detector_unit_defines.svh -----
// Assertion macros shared by the audio filter level detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef AUDIO_FILTER_LEVEL_DETECTOR_UNIT_DEFINES_SVH
`define AUDIO_FILTER_LEVEL_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AFLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afld assertion failed");

// next-cycle implication, disabled during reset
`define AFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afld assertion failed");

`endif

// ----- hdl/afld_pkg.sv -----
// Package for the audio filter level detector: widths, codes, command and
// status structs, saturation helpers. No dependencies.
`default_nettype none

package afld_pkg;

    // block length limit of the level detector
    localparam int MAX_BLOCK = 4096;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W     = CNT_W + 15;
    localparam int NUM_W     = SUM_W + 1;
    localparam int DIVC_W    = $clog2(NUM_W);

    // datapath widths
    localparam int SMP_W   = 16;
    localparam int Q23_W   = 24;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 45;
    localparam int LEVEL_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LP_COEF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HP_COEF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_SEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd5;

    // detector modes
    localparam logic [1:0] DET_NONE  = 2'd0;
    localparam logic [1:0] DET_COUNT = 2'd1;
    localparam logic [1:0] DET_MEAN  = 2'd2;

    // shared multiplier operand selection
    localparam logic [1:0] MUL_GAIN = 2'd0;
    localparam logic [1:0] MUL_LP   = 2'd1;
    localparam logic [1:0] MUL_HP   = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       post_gain;
        logic       post_lp;
        logic       post_hp;
        logic       fin_calc;
        logic       div_load;
        logic       div_step;
        logic       load_out;
    } afld_cmd_t;

    typedef struct packed {
        logic lp_en;
        logic hp_en;
        logic need_div;
        logic div_done;
        logic out_free;
    } afld_sts_t;

    // saturate to signed 16 bits
    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 45'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -45'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

    // saturate to signed 24 bits
    function automatic logic signed [Q23_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [Q23_W-1:0] r;
        if (v > 45'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -45'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[Q23_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/afld_ctrl.sv -----
// Sequencer for the audio filter level detector: steps one request through
// gain, filters, detector update and the end-of-block divide. Uses afld_pkg.
`default_nettype none
`include "audio_filter_level_detector_unit_defines.svh"

module afld_ctrl
    import afld_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire afld_sts_t sts,
    output afld_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_G_MUL    = 4'd1;
    localparam logic [3:0] ST_G_POST   = 4'd2;
    localparam logic [3:0] ST_LP_MUL   = 4'd3;
    localparam logic [3:0] ST_LP_POST  = 4'd4;
    localparam logic [3:0] ST_HP_MUL   = 4'd5;
    localparam logic [3:0] ST_HP_POST  = 4'd6;
    localparam logic [3:0] ST_FIN_CALC = 4'd7;
    localparam logic [3:0] ST_DIV_LOAD = 4'd8;
    localparam logic [3:0] ST_DIV_STEP = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_GAIN;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_G_MUL;
                end
            end
            ST_G_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = ST_G_POST;
            end
            ST_G_POST: begin
                cmd.post_gain = 1'b1;
                if (sts.lp_en) begin
                    state_next = ST_LP_MUL;
                end else if (sts.hp_en) begin
                    state_next = ST_HP_MUL;
                end else begin
                    state_next = ST_FIN_CALC;
                end
            end
            ST_LP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LP;
                state_next  = ST_LP_POST;
            end
            ST_LP_POST: begin
                cmd.post_lp = 1'b1;
                state_next  = sts.hp_en ? ST_HP_MUL : ST_FIN_CALC;
            end
            ST_HP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HP;
                state_next  = ST_HP_POST;
            end
            ST_HP_POST: begin
                cmd.post_hp = 1'b1;
                state_next  = ST_FIN_CALC;
            end
            ST_FIN_CALC: begin
                cmd.fin_calc = 1'b1;
                state_next   = sts.need_div ? ST_DIV_LOAD : ST_FIN;
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a result is only written into a free output register
    `AFLD_ASSERT_IMP(a_load_out_free, aclk, aresetn, cmd.load_out, sts.out_free)
    // the divider is only started for a mean-mode block end
    `AFLD_ASSERT_IMP(a_div_only_mean, aclk, aresetn, cmd.div_load, sts.need_div)
    // the last divide step hands over to the output stage
    `AFLD_ASSERT_NEXT(a_div_to_fin, aclk, aresetn,
        (state_reg == ST_DIV_STEP) && sts.div_done, state_reg == ST_FIN)
    // an accepted request starts with the gain multiply
    `AFLD_ASSERT_NEXT(a_accept_to_gain, aclk, aresetn,
        s_tvalid && s_tready, state_reg == ST_G_MUL)

endmodule

`default_nettype wire

// ----- hdl/afld_datapath.sv -----
// Datapath of the audio filter level detector: configuration registers,
// shared multiplier, filter state, detector, divider, output register.
// Uses afld_pkg; driven by afld_ctrl.
`default_nettype none

module afld_datapath
    import afld_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    // input payload
    input  wire logic [SMP_W-1:0]     s_tdata,
    input  wire logic                 s_tlast,
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast,
    // control
    input  wire afld_cmd_t            cmd,
    output afld_sts_t                 sts
);

    // configuration
    logic [15:0] gain_reg;
    logic [1:0]  filter_sel_reg;
    logic [15:0] lp_coef_reg;
    logic [15:0] hp_coef_reg;
    logic [1:0]  detect_sel_reg;
    logic [15:0] threshold_reg;

    // request and working registers
    logic signed [SMP_W-1:0]  in_sample_reg;
    logic                     last_reg;
    logic signed [Q23_W-1:0]  v_reg, v_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SMP_W-1:0]  s_reg, s_next;

    // filter state
    logic signed [Q23_W-1:0] lp_prev_reg, lp_prev_next;
    logic signed [Q23_W-1:0] hp_out_reg, hp_out_next;
    logic signed [Q23_W-1:0] hp_in_reg, hp_in_next;

    // detector state
    logic [SUM_W-1:0] abs_sum_reg, abs_sum_next;
    logic [CNT_W-1:0] hit_reg, hit_next;
    logic [CNT_W-1:0] samples_reg, samples_next;

    // divider
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DIVC_W-1:0] div_cnt_reg, div_cnt_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic signed [SMP_W-1:0] out_sample_reg;
    logic [LEVEL_W-1:0]      out_level_reg, out_level_next;
    logic                    out_lvalid_reg, out_lvalid_next;
    logic                    out_last_reg;

    // combinational helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  rnd8, rnd16, fin_rnd, lp_sum;
    logic signed [Q23_W-1:0]   sat_q23;
    logic [SMP_W:0]            s_neg;
    logic [SMP_W-1:0]          mag;
    logic [CNT_W:0]            rem_sh;
    logic                      div_ge;
    logic                      det_level;
    logic [63:0]               hit_wide, num_wide;
    logic [LEVEL_W-1:0]        hit_level, mean_level;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= 16'd256;
            filter_sel_reg <= 2'd0;
            lp_coef_reg    <= 16'd0;
            hp_coef_reg    <= 16'd0;
            detect_sel_reg <= DET_NONE;
            threshold_reg  <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN:       gain_reg       <= cfg_data;
                REG_FILTER_SEL: filter_sel_reg <= cfg_data[1:0];
                REG_LP_COEF:    lp_coef_reg    <= cfg_data;
                REG_HP_COEF:    hp_coef_reg    <= cfg_data;
                REG_DETECT_SEL: detect_sel_reg <= cfg_data[1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb begin
        case (cmd.mul_sel)
            MUL_GAIN: begin
                mul_a = MUL_A_W'(in_sample_reg);
                mul_b = $signed({2'b00, gain_reg});
            end
            MUL_LP: begin
                mul_a = MUL_A_W'(v_reg) - MUL_A_W'(lp_prev_reg);
                mul_b = $signed({2'b00, lp_coef_reg});
            end
            MUL_HP: begin
                mul_a = MUL_A_W'(hp_out_reg) + MUL_A_W'(v_reg) - MUL_A_W'(hp_in_reg);
                mul_b = $signed({2'b00, hp_coef_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding of the registered product and of the final Q1.23 value
    assign rnd8    = (prod_reg + 45'sd128) >>> 8;
    assign rnd16   = (prod_reg + 45'sd32768) >>> 16;
    assign lp_sum  = PROD_W'(lp_prev_reg) + rnd16;
    assign sat_q23 = cmd.post_lp ? sat24(lp_sum) : sat24(rnd16);
    assign fin_rnd = (PROD_W'(v_reg) + 45'sd128) >>> 8;

    // magnitude of the output sample
    always_comb begin
        s_next = sat16(fin_rnd);
        s_neg  = -{s_next[SMP_W-1], s_next};
        mag    = s_next[SMP_W-1] ? s_neg[SMP_W-1:0] : s_next;
    end

    // divider step: restoring, one quotient bit per cycle
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, samples_reg};

    // level selection with saturation to 16 bits
    assign hit_wide   = 64'(hit_reg);
    assign num_wide   = 64'(num_reg);
    assign hit_level  = (hit_wide > 64'hFFFF) ? 16'hFFFF : hit_wide[LEVEL_W-1:0];
    assign mean_level = (num_wide > 64'hFFFF) ? 16'hFFFF : num_wide[LEVEL_W-1:0];
    assign det_level  = last_reg && (detect_sel_reg == DET_COUNT ||
                                     detect_sel_reg == DET_MEAN);

    // next-state logic of the datapath
    always_comb begin
        v_next          = v_reg;
        lp_prev_next    = lp_prev_reg;
        hp_out_next     = hp_out_reg;
        hp_in_next      = hp_in_reg;
        abs_sum_next    = abs_sum_reg;
        hit_next        = hit_reg;
        samples_next    = samples_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_level_next  = out_level_reg;
        out_lvalid_next = out_lvalid_reg;

        if (cmd.post_gain) begin
            v_next = {sat16(rnd8), 8'h00};
        end
        if (cmd.post_lp) begin
            lp_prev_next = sat_q23;
            v_next       = sat_q23;
        end
        if (cmd.post_hp) begin
            hp_in_next  = v_reg;
            hp_out_next = sat_q23;
            v_next      = sat_q23;
        end
        // detector accumulation, limited to the block length limit
        if (cmd.fin_calc && samples_reg < CNT_W'(MAX_BLOCK)) begin
            samples_next = samples_reg + 1'b1;
            abs_sum_next = abs_sum_reg + SUM_W'(mag);
            if (threshold_reg != 16'd0 && mag >= threshold_reg) begin
                hit_next = hit_reg + 1'b1;
            end
        end
        if (cmd.div_load) begin
            num_next     = NUM_W'(abs_sum_reg) + NUM_W'(samples_reg >> 1);
            rem_next     = '0;
            div_cnt_next = '0;
        end
        if (cmd.div_step) begin
            rem_next     = div_ge ? CNT_W'(rem_sh - {1'b0, samples_reg}) : rem_sh[CNT_W-1:0];
            num_next     = {num_reg[NUM_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            m_valid_next    = 1'b1;
            out_lvalid_next = det_level;
            if (!det_level) begin
                out_level_next = '0;
            end else if (detect_sel_reg == DET_COUNT) begin
                out_level_next = hit_level;
            end else begin
                out_level_next = mean_level;
            end
            // accumulators restart after every block end
            if (last_reg) begin
                abs_sum_next = '0;
                hit_next     = '0;
                samples_next = '0;
            end
        end
    end

    // state registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_prev_reg <= '0;
            hp_out_reg  <= '0;
            hp_in_reg   <= '0;
            abs_sum_reg <= '0;
            hit_reg     <= '0;
            samples_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            lp_prev_reg <= lp_prev_next;
            hp_out_reg  <= hp_out_next;
            hp_in_reg   <= hp_in_next;
            abs_sum_reg <= abs_sum_next;
            hit_reg     <= hit_next;
            samples_reg <= samples_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_sample_reg <= $signed(s_tdata);
            last_reg      <= s_tlast;
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.fin_calc) begin
            s_reg <= s_next;
        end
        if (cmd.load_out) begin
            out_sample_reg <= s_reg;
            out_last_reg   <= last_reg;
        end
        v_reg          <= v_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        out_level_reg  <= out_level_next;
        out_lvalid_reg <= out_lvalid_next;
    end

    // status back to the sequencer
    assign sts.lp_en    = filter_sel_reg[0];
    assign sts.hp_en    = filter_sel_reg[1];
    assign sts.need_div = last_reg && (detect_sel_reg == DET_MEAN);
    assign sts.div_done = (div_cnt_reg == DIVC_W'(NUM_W - 1));
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_level_reg, out_sample_reg};
    assign m_tuser  = out_lvalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/audio_filter_level_detector_unit.sv -----
// Audio filter level detector: the sequencer walks the gain multiply and
// each enabled filter stage through one shared multiplier (a multiply state
// and a post state each: gain, then low pass and/or high pass, both for band
// pass), then updates the detector and loads the result into the output
// register. On a block end in mean mode the restoring divider runs before
// the load (a load state, then one quotient bit per cycle over a 29-bit
// dividend). The next request is accepted in the cycle after a result is
// loaded; the input takes no new request while an earlier one is still in
// progress in the sequencer or divider. A new request is taken while a
// finished result still waits in the output register; a second finished
// result then holds the sequencer until the output register frees up.
// Configuration writes are accepted in every cycle (cfg_ready is tied high)
// and must only be issued while the block is idle.
// Top level; depends on afld_pkg, afld_ctrl and afld_datapath.
`default_nettype none

module audio_filter_level_detector_unit
    import afld_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    // input samples
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [15:0] sample_in
    input  wire logic                 s_tlast,   // block_end
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // [15:0] sample_out, [31:16] level_value
    output logic                      m_tuser,   // level_valid
    output logic                      m_tlast    // block_last
);

    afld_cmd_t cmd;
    afld_sts_t sts;

    afld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    afld_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
